/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define CMAP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define CMAP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define CMAP_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define CMAP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/cmap_pkg.sv */
`default_nettype none
package cmap_pkg;
   localparam int DENSE_MAX         = 1024;
   localparam int SEGMENT_MAX       = 256;
   localparam int SEGMENT_GLYPH_MAX = 1024;
   localparam int GROUP_MAX         = 256;
   localparam int BYTE_DEPTH        = 256;
   localparam int WORD_DEPTH        = SEGMENT_MAX + SEGMENT_GLYPH_MAX;

   localparam int BYTE_AW  = $clog2(BYTE_DEPTH);
   localparam int DENSE_AW = $clog2(DENSE_MAX);
   localparam int SEG_AW   = $clog2(SEGMENT_MAX);
   localparam int WORD_AW  = $clog2(WORD_DEPTH);
   localparam int GRP_AW   = $clog2(GROUP_MAX);

   localparam int SRCH_MAX = (SEGMENT_MAX > GROUP_MAX) ? SEGMENT_MAX : GROUP_MAX;
   localparam int SRCH_AW  = (SRCH_MAX > 1) ? $clog2(SRCH_MAX) : 1;
   localparam int SRCH_W   = SRCH_AW + 2;

   localparam int ALU_W    = 22;
   localparam int WADDR_W  = 18;

   localparam int REQ_W    = 104;
   localparam int RSP_W    = 24;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 16;

   typedef logic [2:0] opcode_type;
   localparam opcode_type OP_LOOKUP  = 3'd0;
   localparam opcode_type OP_BYTE    = 3'd1;
   localparam opcode_type OP_DENSE   = 3'd2;
   localparam opcode_type OP_SEGMENT = 3'd3;
   localparam opcode_type OP_WORD    = 3'd4;
   localparam opcode_type OP_GROUP   = 3'd5;

   typedef logic [2:0] found_type;
   localparam found_type FOUND_NONE    = 3'd0;
   localparam found_type FOUND_BYTE    = 3'd1;
   localparam found_type FOUND_DENSE   = 3'd2;
   localparam found_type FOUND_SEGMENT = 3'd3;
   localparam found_type FOUND_GROUP   = 3'd4;

   typedef logic [CSR_AW-1:0] csr_idx_type;
   localparam csr_idx_type CSR_MASK        = 3'd0;
   localparam csr_idx_type CSR_DENSE_FIRST = 3'd1;
   localparam csr_idx_type CSR_DENSE_COUNT = 3'd2;
   localparam csr_idx_type CSR_SEG_COUNT   = 3'd3;
   localparam csr_idx_type CSR_GRP_COUNT   = 3'd4;

   typedef struct packed {
      logic [15:0] delta;
      logic [15:0] start;
      logic [15:0] end_code;
   } seg_entry_type;

   typedef struct packed {
      logic [15:0] start_glyph;
      logic [20:0] end_code;
      logic [20:0] start_code;
   } grp_entry_type;
endpackage
`default_nettype wire

/* rtl/core/cmap_ram.sv */
`default_nettype none
module cmap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

/* rtl/core/cmap_alu.sv */
`default_nettype none
// Shared subtract/compare unit used by the dense index and both searches.
module cmap_alu (
   input  logic [cmap_pkg::ALU_W-1:0] a_val,
   input  logic [cmap_pkg::ALU_W-1:0] b_val,
   output logic [cmap_pkg::ALU_W-1:0] diff,
   output logic                       ge
);
   import cmap_pkg::*;
   logic [ALU_W:0] full;

   assign full = {1'b0, a_val} - {1'b0, b_val};
   assign diff = full[ALU_W-1:0];
   assign ge   = ~full[ALU_W];
endmodule
`default_nettype wire

/* rtl/core/font_cmap_glyph_lookup.sv */
`default_nettype none
// Character code to glyph index lookup over font character-map tables.
// req_ beats carry a table write (opcodes 1..5 fill the byte, dense,
// segment, offset/glyph word and group stores), a lookup (opcode 0) or nothing (6, 7).
// Every req beat yields exactly one rsp beat: glyph, source table, bad flag.
// A lookup tries byte table, dense range, segment search and group search in
// that order and stops at the first nonzero glyph.
// csr_ writes the enable mask and table sizes; write only while idle.
// A write goes from accept to S_DONE and then loads the output register. A
// lookup walks the states of each enabled table in turn; each binary-search
// probe passes a probe state and a check state through one shared compare unit
// and the registered read of the table RAMs (up to 9 probes per search).
// One item is in flight at a time: req_tready is high only while idle.
// The result sits in an output register, so req_tready returns as soon as it
// is loaded even while rsp_tready is low; a following result then holds in
// the sequencer until the register empties.
// Reset (synchronous) clears the sequencer, rsp_tvalid and all csr registers;
// table RAM contents are undefined until written.
module font_cmap_glyph_lookup (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // opcode, slot, char_code, word_a, word_b, word_c, word_d
   input  logic [cmap_pkg::REQ_W-1:0]   req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // glyph_index, found_in, bad_slot, zero pad
   output logic [cmap_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                         csr_we,
   input  logic [cmap_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [cmap_pkg::CSR_DW-1:0]  csr_wdata
);
   import cmap_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE      = 13'b0000000000001,
      S_BYTE      = 13'b0000000000010,
      S_DENSE_IDX = 13'b0000000000100,
      S_DENSE_CHK = 13'b0000000001000,
      S_SEG_INIT  = 13'b0000000010000,
      S_SEG_PROBE = 13'b0000000100000,
      S_SEG_CHK   = 13'b0000001000000,
      S_SEG_OFF   = 13'b0000010000000,
      S_SEG_WORD  = 13'b0000100000000,
      S_GRP_INIT  = 13'b0001000000000,
      S_GRP_PROBE = 13'b0010000000000,
      S_GRP_CHK   = 13'b0100000000000,
      S_DONE      = 13'b1000000000000
   } state_type;

   // Input beat fields
   opcode_type  req_op;
   logic [10:0] req_slot;
   logic [20:0] req_code;
   logic [20:0] req_wa;
   logic [15:0] req_wb;
   logic [15:0] req_wc;
   logic [15:0] req_wd;

   assign req_op   = req_tdata[2:0];
   assign req_slot = req_tdata[13:3];
   assign req_code = req_tdata[34:14];
   assign req_wa   = req_tdata[55:35];
   assign req_wb   = req_tdata[71:56];
   assign req_wc   = req_tdata[87:72];
   assign req_wd   = req_tdata[103:88];

   // Control registers
   logic [3:0]  mask_ff;
   logic [15:0] dense_first_ff;
   logic [10:0] dense_count_ff;
   logic [8:0]  seg_count_ff;
   logic [8:0]  grp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff        <= '0;
         dense_first_ff <= '0;
         dense_count_ff <= '0;
         seg_count_ff   <= '0;
         grp_count_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_MASK:        mask_ff        <= csr_wdata[3:0];
            CSR_DENSE_FIRST: dense_first_ff <= csr_wdata;
            CSR_DENSE_COUNT: dense_count_ff <= csr_wdata[10:0];
            CSR_SEG_COUNT:   seg_count_ff   <= csr_wdata[8:0];
            CSR_GRP_COUNT:   grp_count_ff   <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // Sequencer registers
   state_type          state_ff, state_in;
   logic [20:0]        code_ff, code_in;
   logic signed [SRCH_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [SRCH_AW-1:0] mid_ff, mid_in;
   logic [15:0]        glyph_ff, glyph_in;
   found_type          where_ff, where_in;
   logic               bad_ff, bad_in;
   logic [15:0]        seg_start_ff, seg_start_in;
   logic [15:0]        seg_delta_ff, seg_delta_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   logic accept;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;

   // Table writes happen at the accept edge
   logic slot_byte_ok, slot_dense_ok, slot_seg_ok, slot_word_ok, slot_grp_ok;
   logic byte_we, dense_we, seg_we, word_we, grp_we, wr_bad;

   assign slot_byte_ok  = 32'(req_slot) < BYTE_DEPTH;
   assign slot_dense_ok = 32'(req_slot) < DENSE_MAX;
   assign slot_seg_ok   = 32'(req_slot) < SEGMENT_MAX;
   assign slot_word_ok  = 32'(req_slot) < WORD_DEPTH;
   assign slot_grp_ok   = 32'(req_slot) < GROUP_MAX;

   assign byte_we  = accept && (req_op == OP_BYTE) && slot_byte_ok;
   assign dense_we = accept && (req_op == OP_DENSE) && slot_dense_ok;
   assign seg_we   = accept && (req_op == OP_SEGMENT) && slot_seg_ok;
   assign word_we  = accept && (((req_op == OP_SEGMENT) && slot_seg_ok) ||
                                ((req_op == OP_WORD) && slot_word_ok));
   assign grp_we   = accept && (req_op == OP_GROUP) && slot_grp_ok;

   always_comb begin
      priority case (req_op)
         OP_BYTE:    wr_bad = !slot_byte_ok;
         OP_DENSE:   wr_bad = !slot_dense_ok;
         OP_SEGMENT: wr_bad = !slot_seg_ok;
         OP_WORD:    wr_bad = !slot_word_ok;
         OP_GROUP:   wr_bad = !slot_grp_ok;
         default:    wr_bad = 1'b0;
      endcase
   end

   // Shared compare unit
   logic [ALU_W-1:0] alu_a, alu_b, alu_diff;
   logic             alu_ge;

   cmap_alu u_alu (
      .a_val (alu_a),
      .b_val (alu_b),
      .diff  (alu_diff),
      .ge    (alu_ge)
   );

   // Search midpoint
   logic signed [SRCH_W:0] probe_sum;
   logic [SRCH_AW-1:0]     probe_mid;
   assign probe_sum = {lo_ff[SRCH_W-1], lo_ff} + {hi_ff[SRCH_W-1], hi_ff};
   assign probe_mid = probe_sum[SRCH_AW:1];

   // Table RAMs
   logic [7:0]     byte_rdata;
   logic [15:0]    dense_rdata;
   seg_entry_type  seg_rd, seg_wr;
   grp_entry_type  grp_rd, grp_wr;
   logic [15:0]    word_rdata, word_wdata;
   logic [WORD_AW-1:0] word_raddr;
   logic [WADDR_W-1:0] word_addr;

   assign seg_wr     = '{delta: req_wc, start: req_wb, end_code: req_wa[15:0]};
   assign grp_wr     = '{start_glyph: req_wb, end_code: req_wa, start_code: req_code};
   assign word_wdata = (req_op == OP_SEGMENT) ? req_wd : req_wa[15:0];

   // Offset word address: segment index + offset/2 + (code - start)
   assign word_addr = WADDR_W'(mid_ff) + WADDR_W'(word_rdata[15:1]) +
                      WADDR_W'(code_ff[15:0] - seg_start_ff);
   assign word_raddr = (state_ff == S_SEG_CHK) ? WORD_AW'(mid_ff) : WORD_AW'(word_addr);

   cmap_ram #(.WIDTH(8), .DEPTH(BYTE_DEPTH)) u_byte_ram (
      .clock (clock), .we (byte_we), .waddr (BYTE_AW'(req_slot)),
      .wdata (req_wa[7:0]), .raddr (BYTE_AW'(req_code)), .rdata (byte_rdata)
   );

   cmap_ram #(.WIDTH(16), .DEPTH(DENSE_MAX)) u_dense_ram (
      .clock (clock), .we (dense_we), .waddr (DENSE_AW'(req_slot)),
      .wdata (req_wa[15:0]), .raddr (DENSE_AW'(alu_diff)), .rdata (dense_rdata)
   );

   cmap_ram #(.WIDTH($bits(seg_entry_type)), .DEPTH(SEGMENT_MAX)) u_seg_ram (
      .clock (clock), .we (seg_we), .waddr (SEG_AW'(req_slot)),
      .wdata (seg_wr), .raddr (SEG_AW'(probe_mid)), .rdata (seg_rd)
   );

   cmap_ram #(.WIDTH(16), .DEPTH(WORD_DEPTH)) u_word_ram (
      .clock (clock), .we (word_we), .waddr (WORD_AW'(req_slot)),
      .wdata (word_wdata), .raddr (word_raddr), .rdata (word_rdata)
   );

   cmap_ram #(.WIDTH($bits(grp_entry_type)), .DEPTH(GROUP_MAX)) u_grp_ram (
      .clock (clock), .we (grp_we), .waddr (GRP_AW'(req_slot)),
      .wdata (grp_wr), .raddr (GRP_AW'(probe_mid)), .rdata (grp_rd)
   );

   // Feed the shared unit from whichever step owns it this cycle
   always_comb begin
      priority case (1'b1)
         state_ff[2]: begin   // dense index: code - first
            alu_a = ALU_W'(code_ff);
            alu_b = ALU_W'(dense_first_ff);
         end
         state_ff[6]: begin   // segment end >= code
            alu_a = ALU_W'(seg_rd.end_code);
            alu_b = ALU_W'(code_ff);
         end
         state_ff[11]: begin  // group end >= code
            alu_a = ALU_W'(grp_rd.end_code);
            alu_b = ALU_W'(code_ff);
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end

   // Search bounds and helpers
   logic                     code_le_ffff;
   logic signed [SRCH_W-1:0] seg_hi_init, grp_hi_init, mid_dec, mid_inc;
   logic [15:0]              seg_direct, seg_mapped, grp_glyph;

   assign code_le_ffff = code_ff <= 21'hFFFF;
   assign seg_hi_init  = ((32'(seg_count_ff) > SEGMENT_MAX) ? SRCH_W'(SEGMENT_MAX)
                          : SRCH_W'(seg_count_ff)) - SRCH_W'(1);
   assign grp_hi_init  = ((32'(grp_count_ff) > GROUP_MAX) ? SRCH_W'(GROUP_MAX)
                          : SRCH_W'(grp_count_ff)) - SRCH_W'(1);
   assign mid_dec      = SRCH_W'(mid_ff) - SRCH_W'(1);
   assign mid_inc      = SRCH_W'(mid_ff) + SRCH_W'(1);
   assign seg_direct   = code_ff[15:0] + seg_delta_ff;
   assign seg_mapped   = word_rdata + seg_delta_ff;
   assign grp_glyph    = grp_rd.start_glyph + (code_ff[15:0] - grp_rd.start_code[15:0]);

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      glyph_in     = glyph_ff;
      where_in     = where_ff;
      bad_in       = bad_ff;
      seg_start_in = seg_start_ff;
      seg_delta_in = seg_delta_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               code_in  = req_code;
               glyph_in = '0;
               where_in = FOUND_NONE;
               bad_in   = wr_bad;
               state_in = (req_op == OP_LOOKUP) ? S_BYTE : S_DONE;
            end
         end
         S_BYTE: begin
            if (mask_ff[0] && (code_ff <= 21'hFF) && (byte_rdata != 8'h0)) begin
               glyph_in = {8'h0, byte_rdata};
               where_in = FOUND_BYTE;
               state_in = S_DONE;
            end else begin
               state_in = S_DENSE_IDX;
            end
         end
         S_DENSE_IDX: begin
            state_in = S_SEG_INIT;
            if (mask_ff[2] && code_le_ffff && alu_ge && (alu_diff < ALU_W'(dense_count_ff))) begin
               if (32'(alu_diff) >= DENSE_MAX) begin
                  bad_in = 1'b1;
               end else begin
                  state_in = S_DENSE_CHK;
               end
            end
         end
         S_DENSE_CHK: begin
            if (dense_rdata != 16'h0) begin
               glyph_in = dense_rdata;
               where_in = FOUND_DENSE;
               state_in = S_DONE;
            end else begin
               state_in = S_SEG_INIT;
            end
         end
         S_SEG_INIT: begin
            if (mask_ff[1] && code_le_ffff) begin
               lo_in    = '0;
               hi_in    = seg_hi_init;
               state_in = S_SEG_PROBE;
            end else begin
               state_in = S_GRP_INIT;
            end
         end
         S_SEG_PROBE: begin
            if (lo_ff > hi_ff) begin
               state_in = S_GRP_INIT;
            end else begin
               mid_in   = probe_mid;
               state_in = S_SEG_CHK;
            end
         end
         S_SEG_CHK: begin
            if (alu_ge) begin
               if (seg_rd.start <= code_ff[15:0]) begin
                  seg_start_in = seg_rd.start;
                  seg_delta_in = seg_rd.delta;
                  state_in     = S_SEG_OFF;
               end else begin
                  hi_in    = mid_dec;
                  state_in = S_SEG_PROBE;
               end
            end else begin
               lo_in    = mid_inc;
               state_in = S_SEG_PROBE;
            end
         end
         S_SEG_OFF: begin
            // Zero offset: map by delta alone
            if (word_rdata == 16'h0) begin
               if (seg_direct != 16'h0) begin
                  glyph_in = seg_direct;
                  where_in = FOUND_SEGMENT;
                  state_in = S_DONE;
               end else begin
                  state_in = S_GRP_INIT;
               end
            end else if (32'(word_addr) >= WORD_DEPTH) begin
               bad_in   = 1'b1;
               state_in = S_GRP_INIT;
            end else begin
               state_in = S_SEG_WORD;
            end
         end
         S_SEG_WORD: begin
            // A zero glyph word stays zero; otherwise add the delta
            if ((word_rdata != 16'h0) && (seg_mapped != 16'h0)) begin
               glyph_in = seg_mapped;
               where_in = FOUND_SEGMENT;
               state_in = S_DONE;
            end else begin
               state_in = S_GRP_INIT;
            end
         end
         S_GRP_INIT: begin
            if (mask_ff[3]) begin
               lo_in    = '0;
               hi_in    = grp_hi_init;
               state_in = S_GRP_PROBE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_GRP_PROBE: begin
            if (lo_ff > hi_ff) begin
               state_in = S_DONE;
            end else begin
               mid_in   = probe_mid;
               state_in = S_GRP_CHK;
            end
         end
         S_GRP_CHK: begin
            if (alu_ge) begin
               if (grp_rd.start_code <= code_ff) begin
                  if (grp_glyph != 16'h0) begin
                     glyph_in = grp_glyph;
                     where_in = FOUND_GROUP;
                  end
                  state_in = S_DONE;
               end else begin
                  hi_in    = mid_dec;
                  state_in = S_GRP_PROBE;
               end
            end else begin
               lo_in    = mid_inc;
               state_in = S_GRP_PROBE;
            end
         end
         S_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {(RSP_W - 20)'(0), bad_ff, where_ff, glyph_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff      <= code_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      glyph_ff     <= glyph_in;
      where_ff     <= where_in;
      bad_ff       <= bad_in;
      seg_start_ff <= seg_start_in;
      seg_delta_ff <= seg_delta_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`include "assert_macros.svh"

   `CMAP_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_tready)
   `CMAP_ASSERT_NEXT(a_write_goes_done, clock, reset, accept && (req_op != OP_LOOKUP), (state_ff == S_DONE) && (where_ff == FOUND_NONE) && (glyph_ff == 16'h0))
   `CMAP_ASSERT_IMPLY(a_found_has_glyph, clock, reset, rsp_valid_ff, (rsp_data_ff[18:16] == FOUND_NONE) || (rsp_data_ff[15:0] != 16'h0))
endmodule
`default_nettype wire

/* verif/cmap_lookup_checker.sv */
`default_nettype none
module cmap_lookup_checker
   import cmap_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [RSP_W-1:0]  rsp_tdata,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata,
   output int                fail_count,
   output int                pending
);
   typedef struct packed {
      logic [15:0] glyph;
      found_type   src;
      logic        bad;
   } glyph_result_t;

   glyph_result_t glyph_expect_q[$];

   logic [3:0]  enable_mask;
   logic [15:0] dense_first;
   logic [10:0] dense_count;
   logic [8:0]  seg_count;
   logic [8:0]  grp_count;

   logic [7:0]  byte_mem[BYTE_DEPTH];
   logic [15:0] dense_mem[DENSE_MAX];
   logic [15:0] seg_end_mem[SEGMENT_MAX];
   logic [15:0] seg_start_mem[SEGMENT_MAX];
   logic [15:0] seg_delta_mem[SEGMENT_MAX];
   logic [15:0] word_mem[WORD_DEPTH];
   logic [20:0] grp_start_mem[GROUP_MAX];
   logic [20:0] grp_end_mem[GROUP_MAX];
   logic [15:0] grp_glyph_mem[GROUP_MAX];

   function automatic logic [15:0] seg_search(logic [20:0] code, inout logic bad);
      int lo, hi, mid, addr;
      logic [15:0] g;
      lo = 0;
      hi = ((seg_count > SEGMENT_MAX) ? SEGMENT_MAX : int'(seg_count)) - 1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (seg_end_mem[mid] >= code) begin
            if (seg_start_mem[mid] <= code) begin
               if (word_mem[mid] == 0) return 16'(code + seg_delta_mem[mid]);
               addr = mid + word_mem[mid] / 2 + int'(code) - int'(seg_start_mem[mid]);
               if (addr >= WORD_DEPTH) begin
                  bad = 1'b1;
                  return 16'd0;
               end
               g = word_mem[addr];
               // zero word means unmapped, delta only on real glyphs
               return (g != 0) ? 16'(g + seg_delta_mem[mid]) : 16'd0;
            end
            hi = mid - 1;
         end else begin
            lo = mid + 1;
         end
      end
      return 16'd0;
   endfunction

   function automatic logic [15:0] grp_search(logic [20:0] code);
      int lo, hi, mid;
      lo = 0;
      hi = ((grp_count > GROUP_MAX) ? GROUP_MAX : int'(grp_count)) - 1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (grp_end_mem[mid] >= code) begin
            if (grp_start_mem[mid] <= code)
               return 16'(grp_glyph_mem[mid] + (code - grp_start_mem[mid]));
            hi = mid - 1;
         end else begin
            lo = mid + 1;
         end
      end
      return 16'd0;
   endfunction

   // Apply one request beat to the table copy and return the glyph it yields.
   function automatic glyph_result_t predict_glyph(logic [REQ_W-1:0] d);
      opcode_type    op;
      logic [10:0]   slot;
      logic [20:0]   code, wa;
      logic [15:0]   wb, wc, wd;
      glyph_result_t r;
      int            idx;
      op   = d[2:0];
      slot = d[13:3];
      code = d[34:14];
      wa   = d[55:35];
      wb   = d[71:56];
      wc   = d[87:72];
      wd   = d[103:88];
      r    = '0;
      case (op)
         OP_LOOKUP: begin
            if (enable_mask[0] && code <= 21'hFF) begin
               r.glyph = 16'(byte_mem[code[7:0]]);
               if (r.glyph != 0) r.src = FOUND_BYTE;
            end
            if (r.glyph == 0 && enable_mask[2] && code <= 21'hFFFF
                && code >= dense_first) begin
               idx = int'(code) - int'(dense_first);
               if (idx < dense_count) begin
                  if (idx >= DENSE_MAX) r.bad = 1'b1;
                  else r.glyph = dense_mem[idx];
               end
               if (r.glyph != 0) r.src = FOUND_DENSE;
            end
            if (r.glyph == 0 && enable_mask[1] && code <= 21'hFFFF) begin
               r.glyph = seg_search(code, r.bad);
               if (r.glyph != 0) r.src = FOUND_SEGMENT;
            end
            if (r.glyph == 0 && enable_mask[3]) begin
               r.glyph = grp_search(code);
               if (r.glyph != 0) r.src = FOUND_GROUP;
            end
         end
         OP_BYTE:
            if (slot < BYTE_DEPTH) byte_mem[slot] = wa[7:0];
            else r.bad = 1'b1;
         OP_DENSE:
            if (slot < DENSE_MAX) dense_mem[slot] = wa[15:0];
            else r.bad = 1'b1;
         OP_SEGMENT:
            if (slot < SEGMENT_MAX) begin
               seg_end_mem[slot]   = wa[15:0];
               seg_start_mem[slot] = wb;
               seg_delta_mem[slot] = wc;
               word_mem[slot]      = wd;
            end else begin
               r.bad = 1'b1;
            end
         OP_WORD:
            if (slot < WORD_DEPTH) word_mem[slot] = wa[15:0];
            else r.bad = 1'b1;
         OP_GROUP:
            if (slot < GROUP_MAX) begin
               grp_start_mem[slot] = code;
               grp_end_mem[slot]   = wa;
               grp_glyph_mem[slot] = wb;
            end else begin
               r.bad = 1'b1;
            end
         default: ;
      endcase
      return r;
   endfunction

   assign pending = glyph_expect_q.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      glyph_result_t want;
      if (reset) begin
         enable_mask = '0;
         dense_first = '0;
         dense_count = '0;
         seg_count   = '0;
         grp_count   = '0;
         glyph_expect_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_MASK:        enable_mask = csr_wdata[3:0];
               CSR_DENSE_FIRST: dense_first = csr_wdata;
               CSR_DENSE_COUNT: dense_count = csr_wdata[10:0];
               CSR_SEG_COUNT:   seg_count   = csr_wdata[8:0];
               CSR_GRP_COUNT:   grp_count   = csr_wdata[8:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (glyph_expect_q.size() == 0) begin
               $error("unexpected rsp beat %h", rsp_tdata);
               fail_count++;
            end else begin
               want = glyph_expect_q.pop_front();
               if (rsp_tdata[15:0] !== want.glyph) begin
                  $error("glyph_index expected %h got %h", want.glyph, rsp_tdata[15:0]);
                  fail_count++;
               end
               if (rsp_tdata[18:16] !== want.src) begin
                  $error("found_in expected %0d got %0d", want.src, rsp_tdata[18:16]);
                  fail_count++;
               end
               if (rsp_tdata[19] !== want.bad) begin
                  $error("bad_slot expected %b got %b", want.bad, rsp_tdata[19]);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) glyph_expect_q.push_back(predict_glyph(req_tdata));
      end
   end
endmodule
`default_nettype wire

/* verif/tb_font_cmap_glyph_lookup.sv */
`default_nettype none
module tb_font_cmap_glyph_lookup;
   import cmap_pkg::*;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   // opcode, slot, char_code, word_a, word_b, word_c, word_d
   logic [REQ_W-1:0]  req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   // glyph_index, found_in, bad_slot, zero pad
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_we;
   logic [CSR_AW-1:0] csr_addr;
   logic [CSR_DW-1:0] csr_wdata;
   int                fail_count;
   int                pending;

   // Stimulus knobs shared with the receiver process.
   bit                no_gaps;
   bit                hold_rsp;
   int                ready_pct;

   // Ranges of the sorted tables as last loaded, used to aim lookups.
   int                seg_lo[SEGMENT_MAX], seg_hi[SEGMENT_MAX];
   int                grp_lo[GROUP_MAX], grp_hi[GROUP_MAX];
   int                cur_first, cur_dcount, cur_scount, cur_gcount;

   font_cmap_glyph_lookup i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   cmap_lookup_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit: far beyond the slowest legal run, including the long hold.
   initial begin
      #30000000;
      $display("font_cmap_glyph_lookup verification failed");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Receiver: random backpressure, plus one long hold when asked so the
   // output register and the sequencer fill and req_tready drops.
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!no_gaps && $urandom_range(0, 99) < 3) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(10, 30)) @(posedge clock);
         end else begin
            rsp_tready <= no_gaps || ($urandom_range(0, 99) < ready_pct);
            @(posedge clock);
         end
      end
   end

   // Offer one beat; leave tvalid high so a back-to-back beat needs no toggle.
   task automatic send_beat(opcode_type op, int slot, int code, int wa,
                            int wb, int wc, int wd);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {wd[15:0], wc[15:0], wb[15:0], wa[20:0], code[20:0],
                     slot[10:0], op};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drain, then write every register in one burst of csr writes.
   task automatic set_tables(int mask, int first, int dcount, int scount, int gcount);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      cur_first  = first;
      cur_dcount = dcount;
      cur_scount = (scount > SEGMENT_MAX) ? SEGMENT_MAX : scount;
      cur_gcount = (gcount > GROUP_MAX) ? GROUP_MAX : gcount;
      csr_we    <= 1'b1;
      csr_addr  <= CSR_MASK;
      csr_wdata <= CSR_DW'(mask);
      @(posedge clock);
      csr_addr  <= CSR_DENSE_FIRST;
      csr_wdata <= CSR_DW'(first);
      @(posedge clock);
      csr_addr  <= CSR_DENSE_COUNT;
      csr_wdata <= CSR_DW'(dcount);
      @(posedge clock);
      csr_addr  <= CSR_SEG_COUNT;
      csr_wdata <= CSR_DW'(scount);
      @(posedge clock);
      csr_addr  <= CSR_GRP_COUNT;
      csr_wdata <= CSR_DW'(gcount);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Load all segments sorted and non-overlapping; mix delta-only segments,
   // offsets into the glyph words and offsets that run off the store.
   task automatic load_segments();
      int cursor, lo, hi, off, r;
      cursor = $urandom_range(0, 200);
      for (int i = 0; i < SEGMENT_MAX; i++) begin
         lo = cursor + $urandom_range(0, 200);
         hi = lo + $urandom_range(0, 12);
         if (lo > 16'hFFFF) lo = 16'hFFFF;
         if (hi > 16'hFFFF) hi = 16'hFFFF;
         cursor = hi + 1;
         r = $urandom_range(0, 99);
         if (r < 45) off = 0;
         else if (r < 90) off = 2 * (SEGMENT_MAX - i + $urandom_range(0, 1010));
         else off = $urandom_range(1, 16'hFFFF);
         seg_lo[i] = lo;
         seg_hi[i] = hi;
         send_beat(OP_SEGMENT, i, 0, hi, lo, $urandom_range(0, 16'hFFFF), off);
      end
   endtask

   task automatic load_groups();
      int cursor, lo, hi;
      cursor = $urandom_range(0, 1000);
      for (int i = 0; i < GROUP_MAX; i++) begin
         lo = cursor + $urandom_range(0, 3000);
         hi = lo + $urandom_range(0, 800);
         cursor = hi + 1;
         grp_lo[i] = lo;
         grp_hi[i] = hi;
         send_beat(OP_GROUP, i, lo, hi, $urandom_range(0, 16'hFFFF),
                   $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF));
      end
   endtask

   // Glyph values: zero now and then so the fall-through path is hit.
   function automatic int glyph_value();
      return ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 1114111);
   endfunction

   // Aim a lookup at one of the loaded tables, or anywhere.
   function automatic int aim_code();
      int i;
      case ($urandom_range(0, 6))
         0: return $urandom_range(0, 255);
         1: begin
            i = cur_first + $urandom_range(0, cur_dcount + 4);
            return (i > 1114111) ? 1114111 : i;
         end
         2, 3: begin
            if (cur_scount == 0) return $urandom_range(0, 16'hFFFF);
            i = $urandom_range(0, cur_scount - 1);
            return $urandom_range(seg_lo[i], seg_hi[i] + 1);
         end
         4: begin
            if (cur_gcount == 0) return $urandom_range(0, 1114111);
            i = $urandom_range(0, cur_gcount - 1);
            return $urandom_range(grp_lo[i] > 0 ? grp_lo[i] - 1 : 0, grp_hi[i] + 1);
         end
         5: return $urandom_range(0, 16'hFFFF);
         default: return $urandom_range(0, 1114111);
      endcase
   endfunction

   task automatic random_beats(int count);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 78) begin
            send_beat(OP_LOOKUP, $urandom_range(0, 1279), aim_code(),
                      $urandom_range(0, 1114111), $urandom_range(0, 16'hFFFF),
                      $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF));
         end else begin
            // Noise: any opcode but lookup, including unused ones, any slot including
            // ones past the store.
            send_beat(opcode_type'($urandom_range(1, 7)), $urandom_range(0, 1279),
                      $urandom_range(0, 1114111), glyph_value(),
                      $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
                      $urandom_range(0, 16'hFFFF));
         end
      end
   endtask

   initial begin
      int mask, first, dcount, scount, gcount;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= CSR_MASK;
      csr_wdata  <= '0;
      no_gaps    = 1'b0;
      hold_rsp   = 1'b0;
      ready_pct  = 75;
      cur_first  = 0;
      cur_dcount = 0;
      cur_scount = 0;
      cur_gcount = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, tables disabled: nothing read, only write slot checks.
      send_beat(OP_LOOKUP, 0, 0, 0, 0, 0, 0);
      send_beat(OP_LOOKUP, 1279, 1114111, 1114111, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_beat(opcode_type'(6), 1279, 1114111, 1114111, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_beat(opcode_type'(7), 5, 77, 1, 2, 3, 4);
      send_beat(OP_BYTE, 256, 0, 8'h55, 0, 0, 0);
      send_beat(OP_DENSE, 1024, 0, 16'h1234, 0, 0, 0);
      send_beat(OP_SEGMENT, 256, 0, 16'hFFFF, 0, 1, 2);
      send_beat(OP_SEGMENT, 1279, 0, 16'hFFFF, 0, 1, 2);
      send_beat(OP_GROUP, 256, 5, 9, 1, 0, 0);
      send_beat(OP_WORD, 1279, 0, 1114111, 0, 0, 0);

      // Fill every store entry once so no lookup ever sees an unwritten word.
      for (int i = 0; i < BYTE_DEPTH; i++)
         send_beat(OP_BYTE, i, 0, glyph_value(), 0, 0, 0);
      for (int i = 0; i < DENSE_MAX; i++)
         send_beat(OP_DENSE, i, 0, glyph_value(), 0, 0, 0);
      for (int i = 0; i < WORD_DEPTH; i++)
         send_beat(OP_WORD, i, 0, glyph_value(), 0, 0, 0);
      load_segments();
      load_groups();

      // Directed lookups at the code boundaries with everything on.
      set_tables(4'hF, 16'h0100, 1024, 256, 256);
      foreach (seg_lo[i]) if (i == 0) begin
         send_beat(OP_LOOKUP, 0, 0, 0, 0, 0, 0);
         send_beat(OP_LOOKUP, 0, 8'hFF, 0, 0, 0, 0);
         send_beat(OP_LOOKUP, 0, 16'h0100, 0, 0, 0, 0);
         send_beat(OP_LOOKUP, 0, 16'h04FF, 0, 0, 0, 0);
         send_beat(OP_LOOKUP, 0, 16'hFFFF, 0, 0, 0, 0);
         send_beat(OP_LOOKUP, 0, 21'h10000, 0, 0, 0, 0);
         send_beat(OP_LOOKUP, 0, seg_lo[0], 0, 0, 0, 0);
         send_beat(OP_LOOKUP, 0, grp_hi[GROUP_MAX-1], 0, 0, 0, 0);
         send_beat(OP_LOOKUP, 0, 1114111, 0, 0, 0, 0);
      end

      // Phases over several table settings, extremes first.
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: begin mask = 4'hF; first = 0;       dcount = 2047; scount = 511; gcount = 511; end
            1: begin mask = 4'h0; first = 16'hFFFF; dcount = 0;   scount = 0;   gcount = 0;   end
            2: begin mask = 4'hA; first = 16'hFF00; dcount = 1024; scount = 1;  gcount = 1;   end
            3: begin mask = 4'h5; first = 16'hFFFF; dcount = 1100; scount = 256; gcount = 256; end
            default: begin
               mask   = $urandom_range(0, 15);
               first  = $urandom_range(0, 16'hFFFF);
               dcount = $urandom_range(0, 1100);
               scount = $urandom_range(0, 300);
               gcount = $urandom_range(0, 300);
            end
         endcase
         set_tables(mask, first, dcount, scount, gcount);
         no_gaps = (ph == 4) || (ph == 7);
         if (ph % 3 == 1) begin
            load_segments();
            load_groups();
         end
         if (ph == 5) hold_rsp = 1'b1;
         random_beats(150);
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("font_cmap_glyph_lookup verification clean");
      else
         $display("font_cmap_glyph_lookup verification failed");
      $finish;
   end
endmodule
`default_nettype wire
